### hw/rtl/sse_pkg.sv
// Shared types and constants for the sorted sparse entry table.
package sse_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int INDEX_BITS_DEF = 16;
	localparam int FIELD_IDX_W    = 16;
	localparam int VALUE_W        = 32;
	localparam int STATUS_W       = 3;
	localparam int COUNT_OUT_W    = 11;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_SET    = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_ZERO      = 3'd2,
		ST_FULL      = 3'd3,
		ST_FOUND     = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_INSERT,
		S_RESULT
	} state_t;

	// Key compare result: eq when the keys match, gt when the stored key is larger.
	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

### hw/rtl/sse_req_if.sv
// Request channel: one table operation per transfer.
interface sse_req_if;
	logic                               valid;
	logic                               ready;
	logic                               opcode;
	logic [sse_pkg::FIELD_IDX_W-1:0]    row_index;
	logic [sse_pkg::FIELD_IDX_W-1:0]    col_index;
	logic signed [sse_pkg::VALUE_W-1:0] entry_value;

	modport source (output valid, opcode, row_index, col_index, entry_value, input ready);
	modport sink (input valid, opcode, row_index, col_index, entry_value, output ready);
endinterface

### hw/rtl/sse_rsp_if.sv
// Response channel: one result per table operation.
interface sse_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [sse_pkg::VALUE_W-1:0] read_value;
	logic [sse_pkg::STATUS_W-1:0]       status;
	logic [sse_pkg::COUNT_OUT_W-1:0]    entry_count;

	modport source (output valid, read_value, status, entry_count, input ready);
	modport sink (input valid, read_value, status, entry_count, output ready);
endinterface

### hw/rtl/sse_mem.sv
// Entry memory: one write port and one read port with registered read data.
module sse_mem #(
	parameter int DEPTH = sse_pkg::CAPACITY_DEF,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/sse_cmp.sv
// Shared key comparator: orders entries by row and then by column.
module sse_cmp #(
	parameter int SW = 16
) (
	input  logic [SW-1:0]         stored_row,
	input  logic [SW-1:0]         stored_col,
	input  logic [SW-1:0]         new_row,
	input  logic [SW-1:0]         new_col,
	output sse_pkg::cmp_res_t     res
);

	logic [2*SW-1:0] stored_key;
	logic [2*SW-1:0] new_key;

	assign stored_key = {stored_row, stored_col};
	assign new_key    = {new_row, new_col};
	assign res.eq     = (stored_key == new_key);
	assign res.gt     = (stored_key > new_key);

endmodule

### hw/rtl/sorted_sparse_entry_table.sv
// Sorted sparse entry table: sequencer, shared key comparator and entry memory.
// A lookup, update, reject or full result goes from the request transfer through
// the scan, which stops at slot p, and the result state into the output register.
// An insert before the last entry first shifts slots p to n - 1 down by one slot.
// Throughput: one item at a time; the scan and shift both run one slot per cycle
// through the single read port and single write port of the entry memory.
// Reset clears the entry count and control state; the memory is not cleared.
module sorted_sparse_entry_table #(
	parameter int CAPACITY   = sse_pkg::CAPACITY_DEF,
	parameter int INDEX_BITS = sse_pkg::INDEX_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sse_req_if.sink    req,
	sse_rsp_if.source  rsp
);

	// Stored coordinate width: the low INDEX_BITS bits of a 16-bit field.
	localparam int SW    = (INDEX_BITS < sse_pkg::FIELD_IDX_W) ? INDEX_BITS
	                                                          : sse_pkg::FIELD_IDX_W;
	localparam int VW    = sse_pkg::VALUE_W;
	localparam int MW    = 2 * SW + VW;
	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EW    = sse_pkg::COUNT_OUT_W;

	sse_pkg::state_t  state_q, state_d;

	// Captured request.
	sse_pkg::opcode_t op_q;
	logic [SW-1:0]    row_q;
	logic [SW-1:0]    col_q;
	logic [VW-1:0]    val_q;

	// Scan pointer (also the insert slot once the scan has stopped), shift pointer, count.
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [AW-1:0]    sh_q, sh_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] pos_inc;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] count_last;

	// Pending result and the output register.
	logic [VW-1:0]     res_val_q, res_val_d;
	sse_pkg::status_t  res_st_q, res_st_d;
	logic              out_valid_q;
	logic [VW-1:0]     out_val_q;
	logic [2:0]        out_st_q;
	logic [EW-1:0]     out_cnt_q;
	logic              out_free;
	logic              load_out;
	logic [CNT_W+EW-1:0] count_wide;

	// Memory port signals.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [MW-1:0] rd_word;
	logic [SW-1:0] rd_row;
	logic [SW-1:0] rd_col;
	logic [VW-1:0] rd_value;

	sse_pkg::cmp_res_t cmp;
	logic              req_xfer;
	logic              at_tail;
	logic              scan_end;
	logic              scan_hit;

	assign req.ready = (state_q == sse_pkg::S_IDLE);
	assign req_xfer  = req.valid && req.ready;

	assign pos_inc    = pos_q + CNT_W'(1);
	assign count_inc  = count_q + CNT_W'(1);
	assign count_last = count_q - CNT_W'(1);

	assign rd_row   = rd_word[MW-1 -: SW];
	assign rd_col   = rd_word[VW +: SW];
	assign rd_value = rd_word[VW-1:0];

	sse_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (MW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_word)
	);

	// The comparator always looks at the memory's registered read word.
	sse_cmp #(
		.SW (SW)
	) u_cmp (
		.stored_row (rd_row),
		.stored_col (rd_col),
		.new_row    (row_q),
		.new_col    (col_q),
		.res        (cmp)
	);

	// The scan stops at the first slot whose key is not below the new key,
	// or past the last stored entry.
	assign at_tail  = (pos_q == count_q);
	assign scan_end = at_tail || cmp.eq || cmp.gt;
	assign scan_hit = !at_tail && cmp.eq;

	// A result can move to the output register when it is empty or being drained.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sse_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		sh_d      = sh_q;
		count_d   = count_q;
		res_val_d = res_val_q;
		res_st_d  = res_st_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = {row_q, col_q, val_q};
		mem_re    = 1'b0;
		mem_raddr = '0;
		load_out  = 1'b0;
		case (state_q)
			sse_pkg::S_IDLE: begin
				// Start the scan at slot zero; an empty table stops at once.
				if (req.valid) begin
					state_d   = sse_pkg::S_SCAN;
					pos_d     = '0;
					mem_re    = (count_q != '0);
					mem_raddr = '0;
				end
			end
			sse_pkg::S_SCAN: begin
				if (scan_end) begin
					res_val_d = '0;
					state_d   = sse_pkg::S_RESULT;
					if (op_q == sse_pkg::OP_LOOKUP) begin
						res_st_d = scan_hit ? sse_pkg::ST_FOUND : sse_pkg::ST_NOT_FOUND;
						if (scan_hit) begin
							res_val_d = rd_value;
						end
					end else if (val_q == '0) begin
						res_st_d = sse_pkg::ST_ZERO;
					end else if (scan_hit) begin
						mem_we   = 1'b1;
						res_st_d = sse_pkg::ST_UPDATED;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						res_st_d = sse_pkg::ST_FULL;
					end else if (at_tail) begin
						// New largest key: it goes right after the last entry.
						mem_we   = 1'b1;
						count_d  = count_inc;
						res_st_d = sse_pkg::ST_INSERTED;
					end else begin
						// Open a gap: move entries down starting from the last one.
						mem_re    = 1'b1;
						mem_raddr = count_last[AW-1:0];
						sh_d      = count_last[AW-1:0];
						state_d   = sse_pkg::S_SHIFT;
					end
				end else begin
					pos_d     = pos_inc;
					mem_re    = (pos_inc != count_q);
					mem_raddr = pos_inc[AW-1:0];
				end
			end
			sse_pkg::S_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = sh_q + AW'(1);
				mem_wdata = rd_word;
				if (sh_q == pos_q[AW-1:0]) begin
					state_d = sse_pkg::S_INSERT;
				end else begin
					sh_d      = sh_q - AW'(1);
					mem_re    = 1'b1;
					mem_raddr = sh_q - AW'(1);
				end
			end
			sse_pkg::S_INSERT: begin
				mem_we    = 1'b1;
				count_d   = count_inc;
				res_val_d = '0;
				res_st_d  = sse_pkg::ST_INSERTED;
				state_d   = sse_pkg::S_RESULT;
			end
			sse_pkg::S_RESULT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = sse_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sse_pkg::S_IDLE;
			end
		endcase
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q  <= sse_pkg::opcode_t'(req.opcode);
			row_q <= req.row_index[SW-1:0];
			col_q <= req.col_index[SW-1:0];
			val_q <= req.entry_value;
		end
		pos_q     <= pos_d;
		sh_q      <= sh_d;
		res_val_q <= res_val_d;
		res_st_q  <= res_st_d;
	end

	// Output register: holds a finished result until its transfer completes.
	assign count_wide = {EW'(0), count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
			out_cnt_q <= count_wide[EW-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_val_q;
	assign rsp.status      = out_st_q;
	assign rsp.entry_count = out_cnt_q;

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The count only grows, by one, when a new entry is written.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			(count_q == $past(count_inc)) &&
			($past(state_q) == sse_pkg::S_INSERT || $past(state_q) == sse_pkg::S_SCAN))
		else $error("entry count changed outside an insert");

	// The shift pointer never runs below the insert slot.
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sse_pkg::S_SHIFT) |-> (CNT_W'(sh_q) >= pos_q) && (pos_q < count_q))
		else $error("shift pointer below insert slot");

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || rsp.ready))
		else $error("result overwrote a pending response");

endmodule

### tb/sorted_sparse_entry_table_test.sv
// Self-checking testbench for the sorted sparse entry table, with a shadow map as predictor.
module sorted_sparse_entry_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = sse_pkg::CAPACITY_DEF;

	// One table operation as the sender presents it. drain_first holds the item back
	// until every accepted operation has been answered.
	typedef struct {
		sse_pkg::opcode_t                   opcode;
		logic [sse_pkg::FIELD_IDX_W-1:0]    row_index;
		logic [sse_pkg::FIELD_IDX_W-1:0]    col_index;
		logic signed [sse_pkg::VALUE_W-1:0] entry_value;
		bit                                 drain_first;
	} table_op_t;

	// What the block must answer for one operation.
	typedef struct {
		logic signed [sse_pkg::VALUE_W-1:0] read_value;
		sse_pkg::status_t                   status;
		logic [sse_pkg::COUNT_OUT_W-1:0]    entry_count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	sse_req_if req_bus ();
	sse_rsp_if rsp_bus ();

	sorted_sparse_entry_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always #1 clk = ~clk;

	// Shadow of the stored entries, keyed by {row, column}. The block keeps its entries
	// sorted, but sorting is never visible at the ports: only hit or miss, the stored
	// value and the entry count are. A map therefore predicts every result exactly.
	logic [sse_pkg::VALUE_W-1:0] shadow_entries [logic [2*sse_pkg::FIELD_IDX_W-1:0]];

	table_op_t     pending_table_ops[$];   // operations not yet offered to the block
	table_result_t predicted_results[$];   // answers owed for accepted operations
	logic [2*sse_pkg::FIELD_IDX_W-1:0] set_keys[$]; // coordinates written with a nonzero value

	int results_due;    // queued operations whose answer has not been checked yet
	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int checked_count;
	int status_tally [8];

	logic          req_taken;
	table_op_t     next_op;
	table_op_t     taken_op;
	table_result_t want;

	// Predictor: applies one operation to the shadow map and returns the answer.
	function automatic table_result_t apply_table_op(input table_op_t op);
		table_result_t                     res;
		logic [2*sse_pkg::FIELD_IDX_W-1:0] key;
		key = {op.row_index, op.col_index};
		res.read_value = '0;
		if (op.opcode == sse_pkg::OP_LOOKUP) begin
			if (shadow_entries.exists(key)) begin
				res.read_value = shadow_entries[key];
				res.status = sse_pkg::ST_FOUND;
			end else begin
				res.status = sse_pkg::ST_NOT_FOUND;
			end
		end else if (op.entry_value == 0) begin
			// A zero value is never stored, not even over an existing entry.
			res.status = sse_pkg::ST_ZERO;
		end else if (shadow_entries.exists(key)) begin
			// An update is allowed even when the table is full.
			shadow_entries[key] = op.entry_value;
			res.status = sse_pkg::ST_UPDATED;
		end else if (shadow_entries.num() >= CAPACITY) begin
			res.status = sse_pkg::ST_FULL;
		end else begin
			shadow_entries[key] = op.entry_value;
			res.status = sse_pkg::ST_INSERTED;
		end
		res.entry_count = sse_pkg::COUNT_OUT_W'(shadow_entries.num());
		return res;
	endfunction

	task automatic queue_op(input sse_pkg::opcode_t opcode,
			input logic [sse_pkg::FIELD_IDX_W-1:0] row,
			input logic [sse_pkg::FIELD_IDX_W-1:0] col,
			input logic [sse_pkg::VALUE_W-1:0] value,
			input bit drain_first = 1'b0);
		table_op_t op;
		op.opcode      = opcode;
		op.row_index   = row;
		op.col_index   = col;
		op.entry_value = value;
		op.drain_first = drain_first;
		if (opcode == sse_pkg::OP_SET && value != 0) begin
			set_keys.push_back({row, col});
		end
		pending_table_ops.push_back(op);
		results_due++;
	endtask

	// A random key that is not stored yet.
	function automatic logic [2*sse_pkg::FIELD_IDX_W-1:0] fresh_key();
		logic [2*sse_pkg::FIELD_IDX_W-1:0] key;
		do begin
			key = $urandom();
		end while (shadow_entries.exists(key));
		return key;
	endfunction

	// Random operations. Keys are drawn mostly from coordinates that were written
	// before, or from a tiny corner of the index space, so that lookups hit and sets
	// update often; the rest are fully random and almost always new.
	task automatic queue_random_ops(input int count);
		logic [2*sse_pkg::FIELD_IDX_W-1:0] key;
		logic [sse_pkg::VALUE_W-1:0]       value;
		sse_pkg::opcode_t                  opcode;
		int                                pick;
		for (int i = 0; i < count; i++) begin
			opcode = ($urandom_range(99) < 55) ? sse_pkg::OP_SET : sse_pkg::OP_LOOKUP;
			pick = $urandom_range(99);
			if (pick < 45 && set_keys.size() != 0) begin
				key = set_keys[$urandom_range(set_keys.size() - 1)];
			end else if (pick < 75) begin
				key = {16'($urandom_range(7)), 16'($urandom_range(7))};
			end else begin
				key = $urandom();
			end
			pick = $urandom_range(99);
			if (pick < 8) begin
				value = '0;
			end else if (pick < 16) begin
				case ($urandom_range(3))
					0: value = 32'h7fff_ffff;
					1: value = 32'h8000_0000;
					2: value = 32'hffff_ffff;
					default: value = 32'h0000_0001;
				endcase
			end else begin
				value = $urandom();
			end
			queue_op(opcode, key[31:16], key[15:0], value, $urandom_range(99) < 2);
		end
	endtask

	// Sender and receiver. Inputs change at the falling edge only. A new item is
	// offered once the previous one was transferred, unless the sender idles this
	// cycle or the item waits for every outstanding answer first. While idle the
	// payload carries noise so that the block cannot rely on it.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (!req_bus.valid || req_taken) begin
				if (pending_table_ops.size() != 0 && $urandom_range(99) >= send_idle_pct &&
						!(pending_table_ops[0].drain_first && predicted_results.size() != 0)) begin
					next_op = pending_table_ops.pop_front();
					req_bus.valid       <= 1'b1;
					req_bus.opcode      <= next_op.opcode;
					req_bus.row_index   <= next_op.row_index;
					req_bus.col_index   <= next_op.col_index;
					req_bus.entry_value <= next_op.entry_value;
				end else begin
					req_bus.valid       <= 1'b0;
					req_bus.opcode      <= $urandom_range(1);
					req_bus.row_index   <= $urandom();
					req_bus.col_index   <= $urandom();
					req_bus.entry_value <= $urandom();
				end
			end
		end
	end

	// Monitor. At the rising edge an accepted request is run through the predictor,
	// and an accepted result is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_bus.valid && req_bus.ready;
			if (req_bus.valid && req_bus.ready) begin
				taken_op.opcode      = sse_pkg::opcode_t'(req_bus.opcode);
				taken_op.row_index   = req_bus.row_index;
				taken_op.col_index   = req_bus.col_index;
				taken_op.entry_value = req_bus.entry_value;
				taken_op.drain_first = 1'b0;
				predicted_results.push_back(apply_table_op(taken_op));
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result transfer with no operation outstanding");
					error_count++;
				end else begin
					want = predicted_results.pop_front();
					results_due--;
					checked_count++;
					status_tally[want.status]++;
					if (rsp_bus.read_value !== want.read_value) begin
						$error("read_value: expected %0h, got %0h", want.read_value,
							rsp_bus.read_value);
						error_count++;
					end
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
						error_count++;
					end
					if (rsp_bus.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							rsp_bus.entry_count);
						error_count++;
					end
				end
			end
		end
	end

	// Stimulus and phases.
	initial begin
		logic [2*sse_pkg::FIELD_IDX_W-1:0] key;

		arst_n              = 1'b0;
		req_bus.valid       = 1'b0;
		req_bus.opcode      = 1'b0;
		req_bus.row_index   = '0;
		req_bus.col_index   = '0;
		req_bus.entry_value = '0;
		rsp_bus.ready       = 1'b0;
		results_due         = 0;
		error_count         = 0;
		checked_count       = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles often, receiver stalls most of the time.
		send_idle_pct = 35;
		recv_idle_pct = 81;

		// Directed: lookup and zero reject on an empty table, inserts at both ends of the
		// key space and in between, extreme values, an update, and a zero set on an
		// existing entry, which must leave that entry alone.
		queue_op(sse_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 32'h0);
		queue_op(sse_pkg::OP_SET,    16'h0000, 16'h0000, 32'h0);
		queue_op(sse_pkg::OP_SET,    16'h0000, 16'h0000, 32'h7fff_ffff);
		queue_op(sse_pkg::OP_SET,    16'hffff, 16'hffff, 32'h8000_0000);
		queue_op(sse_pkg::OP_SET,    16'hffff, 16'h0000, 32'hffff_ffff);
		queue_op(sse_pkg::OP_SET,    16'h0000, 16'hffff, 32'h0000_0001);
		queue_op(sse_pkg::OP_SET,    16'h8000, 16'h8000, 32'h0001_0000);
		queue_op(sse_pkg::OP_SET,    16'h0000, 16'h0001, 32'h0000_8000);
		queue_op(sse_pkg::OP_SET,    16'h0001, 16'h0000, 32'hffff_8000);
		queue_op(sse_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 32'h0, 1'b1);
		queue_op(sse_pkg::OP_LOOKUP, 16'hffff, 16'hffff, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, 16'h0000, 16'hfffe, 32'h0);
		queue_op(sse_pkg::OP_SET,    16'h0000, 16'h0000, 32'hffff_0000);
		queue_op(sse_pkg::OP_SET,    16'hffff, 16'hffff, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, 16'hffff, 16'hffff, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, 16'hffff, 16'hfffe, 32'h0);
		queue_op(sse_pkg::OP_SET,    16'haaaa, 16'h5555, 32'h5555_5555);
		queue_op(sse_pkg::OP_SET,    16'h5555, 16'haaaa, 32'haaaa_aaaa);
		queue_op(sse_pkg::OP_LOOKUP, 16'h5555, 16'haaaa, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, 16'haaaa, 16'h5555, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 32'h0);
		queue_random_ops(185);
		wait (results_due == 0);

		// Roles swapped: the receiver is now the fast side.
		send_idle_pct = 81;
		recv_idle_pct = 35;
		queue_random_ops(185);
		wait (results_due == 0);

		// Back to back with no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_ops(175);
		wait (results_due == 0);

		// Closing checks: a new key lands among many stored entries, an existing key is
		// updated, zero is still rejected, and lookups hit at both ends of the key space.
		send_idle_pct = 35;
		recv_idle_pct = 81;
		key = fresh_key();
		queue_op(sse_pkg::OP_SET,    key[31:16], key[15:0], 32'h0001_0000);
		queue_op(sse_pkg::OP_SET,    16'h0000, 16'h0000, 32'h0000_0001);
		queue_op(sse_pkg::OP_SET,    16'hffff, 16'hffff, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, 16'hffff, 16'hffff, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 32'h0);
		queue_op(sse_pkg::OP_LOOKUP, key[31:16], key[15:0], 32'h0);
		key = fresh_key();
		queue_op(sse_pkg::OP_SET,    key[31:16], key[15:0], 32'h8000_0000);
		wait (results_due == 0);

		// A full shift plus the result path is the longest the block can take; any
		// stray result in this window is caught by the monitor.
		repeat (CAPACITY + 16) @(posedge clk);
		if (predicted_results.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_results.size());
			error_count++;
		end

		$display("tb: %0d results checked: %0d inserted, %0d updated, %0d zero rejected,",
			checked_count, status_tally[sse_pkg::ST_INSERTED],
			status_tally[sse_pkg::ST_UPDATED], status_tally[sse_pkg::ST_ZERO]);
		$display("tb: %0d refused as full, %0d found, %0d not found; table held %0d of %0d",
			status_tally[sse_pkg::ST_FULL], status_tally[sse_pkg::ST_FOUND],
			status_tally[sse_pkg::ST_NOT_FOUND], shadow_entries.num(), CAPACITY);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run, with every item at a full shift.
	initial begin
		#16_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
